FILE: design/sfp_pkg.sv
// Shared types and constants of the sum-checked frame parser.
`timescale 1ns / 1ps
package sfp_pkg;

  localparam logic [7:0] SYNC0_BYTE    = 8'h46;
  localparam logic [7:0] SYNC1_BYTE    = 8'hB9;
  localparam logic [7:0] SYNC3_BYTE    = 8'h00;
  localparam logic [7:0] END_BYTE      = 8'h16;
  localparam logic [7:0] HEADER_LEN    = 8'd6;
  localparam logic [7:0] DIR_CODE_RST  = 8'h68;

  localparam logic [1:0] VERDICT_NONE  = 2'd0;
  localparam logic [1:0] VERDICT_OK    = 2'd1;
  localparam logic [1:0] VERDICT_ERROR = 2'd2;
  localparam logic [1:0] VERDICT_INCOMPLETE = 2'd3;

  localparam logic [2:0] WHERE_NONE    = 3'd0;
  localparam logic [2:0] WHERE_PREFIX  = 3'd1;
  localparam logic [2:0] WHERE_LENGTH  = 3'd2;
  localparam logic [2:0] WHERE_SUM_HI  = 3'd3;
  localparam logic [2:0] WHERE_SUM_LO  = 3'd4;
  localparam logic [2:0] WHERE_END     = 3'd5;

  localparam int OUT_DATA_W = 32;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [1:0] verdict;
    logic [2:0] error_where;
    logic [7:0] frame_length;
  } result_t;

endpackage

FILE: design/sfp_parser.sv
// Frame parser state and per-word next-state and result logic.
`timescale 1ns / 1ps
module sfp_parser (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic [7:0]      rx_byte,
  input  logic            first_byte,
  input  logic            last_byte,
  input  logic            cfg_we,
  input  logic [7:0]      cfg_data,
  output logic            res_valid,
  output sfp_pkg::result_t res
);
  import sfp_pkg::*;

  typedef enum logic [3:0] {
    PH_SYNC0, PH_SYNC1, PH_DIR, PH_SYNC3, PH_LEN,
    PH_PAYLOAD, PH_SUM_HI, PH_SUM_LO, PH_END
  } phase_t;

  phase_t      phase_r, phase_nxt, ph_base;
  logic [15:0] sum_r, sum_nxt, sum_base;
  logic [7:0]  count_r, count_nxt, count_base;
  logic [7:0]  idx_r, idx_nxt, idx_base, idx_inc;
  logic        fin_r, fin_nxt;
  logic [7:0]  dir_r;
  logic [2:0]  where;

  always_comb begin
    ph_base    = first_byte ? PH_SYNC0 : phase_r;
    sum_base   = first_byte ? 16'd0 : sum_r;
    count_base = first_byte ? 8'd0 : count_r;
    idx_base   = first_byte ? 8'd0 : idx_r;
    fin_nxt    = first_byte ? 1'b0 : fin_r;
    idx_inc    = idx_base + 8'd1;

    phase_nxt = ph_base;
    sum_nxt   = sum_base;
    count_nxt = count_base;
    idx_nxt   = idx_base;
    where     = WHERE_NONE;
    res       = '0;

    if (!fin_nxt) begin
      unique case (ph_base)
        PH_SYNC1: begin
          if (rx_byte != SYNC1_BYTE) where = WHERE_PREFIX;
          else phase_nxt = PH_DIR;
        end
        PH_DIR: begin
          if (rx_byte != dir_r) where = WHERE_PREFIX;
          else phase_nxt = PH_SYNC3;
        end
        PH_SYNC3: begin
          if (rx_byte != SYNC3_BYTE) where = WHERE_PREFIX;
          else phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          if (rx_byte < HEADER_LEN) begin
            where = WHERE_LENGTH;
          end else begin
            sum_nxt   = {8'd0, dir_r} + {8'd0, rx_byte};
            count_nxt = rx_byte - HEADER_LEN;
            idx_nxt   = 8'd0;
            phase_nxt = (count_nxt != 8'd0) ? PH_PAYLOAD : PH_SUM_HI;
          end
        end
        PH_PAYLOAD: begin
          sum_nxt           = sum_base + {8'd0, rx_byte};
          res.payload_valid = 1'b1;
          res.payload_byte  = rx_byte;
          res.payload_index = idx_base;
          idx_nxt           = idx_inc;
          if (idx_inc == count_base) phase_nxt = PH_SUM_HI;
        end
        PH_SUM_HI: begin
          if (rx_byte != sum_base[15:8]) where = WHERE_SUM_HI;
          else phase_nxt = PH_SUM_LO;
        end
        PH_SUM_LO: begin
          if (rx_byte != sum_base[7:0]) where = WHERE_SUM_LO;
          else phase_nxt = PH_END;
        end
        PH_END: begin
          if (rx_byte != END_BYTE) begin
            where = WHERE_END;
          end else begin
            res.verdict      = VERDICT_OK;
            res.frame_length = count_base;
            fin_nxt          = 1'b1;
          end
        end
        default: begin
          if (rx_byte != SYNC0_BYTE) where = WHERE_PREFIX;
          else phase_nxt = PH_SYNC1;
        end
      endcase
      if (where != WHERE_NONE) begin
        res.verdict     = VERDICT_ERROR;
        res.error_where = where;
        fin_nxt         = 1'b1;
      end
    end

    if (last_byte) begin
      if (!fin_nxt) res.verdict = VERDICT_INCOMPLETE;
      phase_nxt = PH_SYNC0;
      sum_nxt   = 16'd0;
      count_nxt = 8'd0;
      idx_nxt   = 8'd0;
      fin_nxt   = 1'b0;
    end

    res_valid = res.payload_valid || (res.verdict != VERDICT_NONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SYNC0;
      sum_r   <= 16'd0;
      count_r <= 8'd0;
      idx_r   <= 8'd0;
      fin_r   <= 1'b0;
      dir_r   <= DIR_CODE_RST;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
        sum_r   <= sum_nxt;
        count_r <= count_nxt;
        idx_r   <= idx_nxt;
        fin_r   <= fin_nxt;
      end
      if (cfg_we) dir_r <= cfg_data;
    end
  end

`ifndef NO_ASSERTIONS
  a_where_is_error: assert property (@(posedge clk) disable iff (!rst_n)
    (res.error_where != WHERE_NONE) |-> (res.verdict == VERDICT_ERROR))
    else $error("error place without error verdict");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && last_byte) |=> (phase_r == PH_SYNC0 && !fin_r && idx_r == 8'd0))
    else $error("state not cleared after buffer end");

  a_ok_from_end: assert property (@(posedge clk) disable iff (!rst_n)
    (res.verdict == VERDICT_OK) |-> (phase_r == PH_END && !first_byte))
    else $error("ok verdict outside end byte phase");

  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (res.payload_valid && !first_byte) |-> (res.payload_index < count_r))
    else $error("payload index beyond payload count");
`endif

endmodule

FILE: design/sfp_out_reg.sv
// Result register between the parser and the output stream.
`timescale 1ns / 1ps
module sfp_out_reg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            load,
  input  sfp_pkg::result_t                res,
  output logic                            slot_free,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [sfp_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                            out_tuser
);
  import sfp_pkg::*;

  logic    valid_r;
  result_t res_r;

  assign slot_free  = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tuser  = res_r.payload_valid;
  assign out_tdata  = {3'd0, res_r.frame_length, res_r.error_where, res_r.verdict,
                       res_r.payload_index, res_r.payload_byte};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (slot_free) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && load) res_r <= res;
  end

endmodule

FILE: design/sum_checked_frame_parser_core.sv
// Top level of the sum-checked frame parser.
// Result words are registered; a result word appears on out_tvalid in the cycle after its input word is taken.
// Throughput: one input word per cycle; in_tready drops only while a result waits.
// The parser state update is combinational logic between state and result registers.
// Reset (rst_n, synchronous): parser returns to sync, direction code becomes 0x68.
`timescale 1ns / 1ps
module sum_checked_frame_parser_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // rx_byte
  input  logic                            in_tuser,   // first_byte
  input  logic                            in_tlast,   // last_byte
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // payload_byte[7:0], payload_index[15:8], verdict[17:16], error_where[20:18],
  // frame_length[28:21], zero[31:29]
  output logic [sfp_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                            out_tuser,  // payload_valid
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [7:0]                      cfg_data    // direction_code
);
  import sfp_pkg::*;

  logic    accept;
  logic    slot_free;
  logic    res_valid;
  result_t res;

  assign in_tready = slot_free;
  assign accept    = in_tvalid && slot_free;
  assign cfg_ready = 1'b1;

  sfp_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .rx_byte    (in_tdata),
    .first_byte (in_tuser),
    .last_byte  (in_tlast),
    .cfg_we     (cfg_valid),
    .cfg_data   (cfg_data),
    .res_valid  (res_valid),
    .res        (res)
  );

  sfp_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept && res_valid),
    .res        (res),
    .slot_free  (slot_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
